/* rtl/b64_pkg.sv */
package b64_pkg;

    // character codes
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_ASCII = 8'h80;

    // sextet values of the two symbol pairs
    localparam logic [5:0] SX_PLUS  = 6'd62;
    localparam logic [5:0] SX_SLASH = 6'd63;

    // decoder phase
    typedef enum logic [1:0] {
        PH_NORMAL   = 2'd0,
        PH_PADRUN   = 2'd1,
        PH_AWAITPAD = 2'd2,
        PH_SWALLOW  = 2'd3
    } phase_t;

    // end of text status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CHAR = 2'd1,
        STATUS_BAD_PAD  = 2'd2
    } status_t;

    // decoded character
    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    // one input item
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } item_t;

    // one result item
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       end_of_text;
        logic [1:0] status;
    } result_t;

    // lookup for both alphabets
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.bad   = 1'b0;
        s.value = '0;
        if (c >= CHAR_ASCII)
        begin
            s.bad = 1'b1;
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            s.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B || c == 8'h2D)
        begin
            s.value = SX_PLUS;
        end
        else if (c == 8'h2F || c == 8'h5F)
        begin
            s.value = SX_SLASH;
        end
        else
        begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

/* rtl/b64_in_stage.sv */
module b64_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  b64_pkg::item_t  item_in,
    input  logic            advance,
    output logic            item_valid,
    output b64_pkg::item_t  item_out
);

    logic           valid_reg;
    logic           valid_next;
    b64_pkg::item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

/* rtl/b64_dec_step.sv */
module b64_dec_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  b64_pkg::item_t    item,
    output logic              res_valid,
    output b64_pkg::result_t  result
);

    logic [1:0]        group_position_reg;
    logic [1:0]        group_position_next;
    logic [5:0]        held_sextet_reg;
    logic [5:0]        held_sextet_next;
    b64_pkg::phase_t   phase_reg;
    b64_pkg::phase_t   phase_next;
    b64_pkg::status_t  error_code_reg;
    b64_pkg::status_t  error_code_next;

    b64_pkg::sextet_t  sx;
    logic              is_pad;
    logic              last;
    logic              byte_ok;
    logic [7:0]        byte_val;
    b64_pkg::status_t  status_val;
    b64_pkg::status_t  fail;

    assign sx     = b64_pkg::sextet_of(item.char_in);
    assign is_pad = (item.char_in == b64_pkg::CHAR_PAD);
    assign last   = item.last_char;

    // decode one character and work out the next state
    always_comb
    begin
        group_position_next = group_position_reg;
        held_sextet_next    = held_sextet_reg;
        phase_next          = phase_reg;
        error_code_next     = error_code_reg;
        byte_ok             = 1'b0;
        byte_val            = '0;
        status_val          = b64_pkg::STATUS_OK;
        fail                = b64_pkg::STATUS_OK;

        unique case (phase_reg)
            b64_pkg::PH_SWALLOW:
            begin
                status_val = error_code_reg;
            end
            b64_pkg::PH_PADRUN:
            begin
                if (!is_pad)
                begin
                    fail = b64_pkg::STATUS_BAD_PAD;
                end
            end
            b64_pkg::PH_AWAITPAD:
            begin
                if (!is_pad || !last)
                begin
                    fail = b64_pkg::STATUS_BAD_PAD;
                end
            end
            b64_pkg::PH_NORMAL:
            begin
                unique case (group_position_reg)
                    2'd0:
                    begin
                        priority if (last)
                        begin
                            if (!is_pad)
                            begin
                                fail = b64_pkg::STATUS_BAD_PAD;
                            end
                        end
                        else if (is_pad)
                        begin
                            phase_next = b64_pkg::PH_PADRUN;
                        end
                        else if (sx.bad)
                        begin
                            fail = b64_pkg::STATUS_BAD_CHAR;
                        end
                        else
                        begin
                            held_sextet_next    = sx.value;
                            group_position_next = 2'd1;
                        end
                    end
                    2'd1:
                    begin
                        if (sx.bad)
                        begin
                            fail = b64_pkg::STATUS_BAD_CHAR;
                        end
                        else
                        begin
                            byte_ok             = 1'b1;
                            byte_val            = {held_sextet_reg, sx.value[5:4]};
                            held_sextet_next    = sx.value;
                            group_position_next = 2'd2;
                        end
                    end
                    2'd2:
                    begin
                        priority if (is_pad)
                        begin
                            if (last)
                            begin
                                fail = b64_pkg::STATUS_BAD_PAD;
                            end
                            else
                            begin
                                phase_next = b64_pkg::PH_AWAITPAD;
                            end
                        end
                        else if (sx.bad)
                        begin
                            fail = b64_pkg::STATUS_BAD_CHAR;
                        end
                        else
                        begin
                            byte_ok             = 1'b1;
                            byte_val            = {held_sextet_reg[3:0], sx.value[5:2]};
                            held_sextet_next    = sx.value;
                            group_position_next = 2'd3;
                        end
                    end
                    2'd3:
                    begin
                        priority if (is_pad)
                        begin
                            if (!last)
                            begin
                                fail = b64_pkg::STATUS_BAD_PAD;
                            end
                        end
                        else if (sx.bad)
                        begin
                            fail = b64_pkg::STATUS_BAD_CHAR;
                        end
                        else
                        begin
                            byte_ok             = 1'b1;
                            byte_val            = {held_sextet_reg[1:0], sx.value};
                            group_position_next = 2'd0;
                        end
                    end
                    default:
                    begin
                        fail = b64_pkg::STATUS_OK;
                    end
                endcase
            end
            default:
            begin
                status_val = b64_pkg::STATUS_OK;
            end
        endcase

        // an error sends the rest of the text to the swallow phase
        if (fail != b64_pkg::STATUS_OK)
        begin
            phase_next      = b64_pkg::PH_SWALLOW;
            error_code_next = fail;
            status_val      = fail;
        end

        // end of text starts a fresh text
        if (last)
        begin
            group_position_next = '0;
            held_sextet_next    = '0;
            phase_next          = b64_pkg::PH_NORMAL;
            error_code_next     = b64_pkg::STATUS_OK;
        end
    end

    // result fields
    assign res_valid          = byte_ok || last;
    assign result.byte_valid  = byte_ok;
    assign result.data_byte   = byte_ok ? byte_val : 8'd0;
    assign result.end_of_text = last;
    assign result.status      = last ? status_val : b64_pkg::STATUS_OK;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_position_reg <= '0;
            held_sextet_reg    <= '0;
            phase_reg          <= b64_pkg::PH_NORMAL;
            error_code_reg     <= b64_pkg::STATUS_OK;
        end
        else if (advance)
        begin
            group_position_reg <= group_position_next;
            held_sextet_reg    <= held_sextet_next;
            phase_reg          <= phase_next;
            error_code_reg     <= error_code_next;
        end
    end

endmodule

/* rtl/b64_out_stage.sv */
module b64_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  b64_pkg::result_t  result_in,
    output logic              out_valid,
    input  logic              out_ready,
    output b64_pkg::result_t  result_out
);

    logic              valid_reg;
    logic              valid_next;
    b64_pkg::result_t  result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

/* rtl/base64_stream_decoder.sv */
// channel   direction  handshake            payload
// input     in         in_valid / in_ready   char_in, last_char
// result    out        out_valid / out_ready byte_valid, data_byte, end_of_text, status
//
// one character per cycle sustained while out_ready is high; a transferred character
// goes to the input register, then decode logic puts its result in the output register
// a character that completes no byte and is not last produces no result
// reset clears both stage valid flags and the decoder state
// with out_ready low the result holds, one more character is held in the input
// register, then in_ready drops
module base64_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       byte_valid,
    output logic [7:0] data_byte,
    output logic       end_of_text,
    output logic [1:0] status
);

    b64_pkg::item_t    item_in;
    b64_pkg::item_t    item;
    logic              item_valid;
    logic              advance;
    logic              res_valid;
    b64_pkg::result_t  result;
    b64_pkg::result_t  result_out;

    assign item_in.char_in   = char_in;
    assign item_in.last_char = last_char;

    // held item moves on when the output register has room
    assign advance = item_valid && (!out_valid || out_ready);

    b64_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    b64_dec_step u_dec_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .result    (result)
    );

    b64_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && res_valid),
        .result_in  (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign byte_valid  = result_out.byte_valid;
    assign data_byte   = result_out.data_byte;
    assign end_of_text = result_out.end_of_text;
    assign status      = result_out.status;

endmodule
